// File: src/bmssc_pkg.sv
package bmssc_pkg;

  localparam int unsigned PeriodWidth = 16;
  localparam int unsigned StepWidth   = 10;
  localparam int unsigned TargetWidth = 11;
  localparam int unsigned DutyWidth   = 10;
  localparam int unsigned CountWidth  = 8;
  localparam int unsigned IndexWidth  = 3;
  localparam int unsigned DataWidth   = 16;

  localparam logic [PeriodWidth-1:0] OPTION_PERIOD_RST = 16'd1000;
  localparam logic [PeriodWidth-1:0] TARGET_PERIOD_RST = 16'd10;
  localparam logic [PeriodWidth-1:0] RAMP_PERIOD_RST   = 16'd20;
  localparam logic [StepWidth-1:0]   TARGET_STEP_RST   = 10'd100;
  localparam logic [TargetWidth-1:0] TARGET_LIMIT_RST  = 11'd1024;

  // option button press counts that carry a meaning on release
  localparam logic [CountWidth-1:0] OPT_TOGGLE_DIR = 8'd1;
  localparam logic [CountWidth-1:0] OPT_STOP       = 8'd2;
  localparam logic [CountWidth-1:0] OPT_START_RAMP = 8'd3;

  // drive_bits codes: bit 0 forward, bit 1 reverse
  localparam logic [1:0] DRIVE_OFF     = 2'b00;
  localparam logic [1:0] DRIVE_FORWARD = 2'b01;
  localparam logic [1:0] DRIVE_REVERSE = 2'b10;
  localparam logic [1:0] DRIVE_BOTH    = 2'b11;

  typedef enum logic [IndexWidth-1:0] {
    REG_OPTION_PERIOD = 3'd0,
    REG_TARGET_PERIOD = 3'd1,
    REG_RAMP_PERIOD   = 3'd2,
    REG_TARGET_STEP   = 3'd3,
    REG_TARGET_LIMIT  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [PeriodWidth-1:0] option_period;
    logic [PeriodWidth-1:0] target_period;
    logic [PeriodWidth-1:0] ramp_period;
    logic [StepWidth-1:0]   target_step;
    logic [TargetWidth-1:0] target_limit;
  } cfg_t;

  typedef struct packed {
    logic                 drive_forward;
    logic                 drive_reverse;
    logic [DutyWidth-1:0] duty_level;
    logic                 ramping;
  } result_t;

endpackage

// File: src/bmssc_cfg_regs.sv
module bmssc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [bmssc_pkg::IndexWidth-1:0] wr_index,
  input  logic [bmssc_pkg::DataWidth-1:0]  wr_data,
  output bmssc_pkg::cfg_t                  cfg
);
  import bmssc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.option_period <= OPTION_PERIOD_RST;
      cfg.target_period <= TARGET_PERIOD_RST;
      cfg.ramp_period   <= RAMP_PERIOD_RST;
      cfg.target_step   <= TARGET_STEP_RST;
      cfg.target_limit  <= TARGET_LIMIT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_OPTION_PERIOD: cfg.option_period <= wr_data;
        REG_TARGET_PERIOD: cfg.target_period <= wr_data;
        REG_RAMP_PERIOD:   cfg.ramp_period   <= wr_data;
        REG_TARGET_STEP:   cfg.target_step   <= wr_data[StepWidth-1:0];
        REG_TARGET_LIMIT:  cfg.target_limit  <= wr_data[TargetWidth-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/bmssc_core.sv
module bmssc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              opt_pressed,
  input  logic              adj_pressed,
  input  bmssc_pkg::cfg_t    cfg,
  output bmssc_pkg::result_t result
);
  import bmssc_pkg::*;

  logic [PeriodWidth-1:0] option_divider, option_divider_next;
  logic [PeriodWidth-1:0] target_divider, target_divider_next;
  logic [PeriodWidth-1:0] ramp_divider, ramp_divider_next;
  logic [CountWidth-1:0]  option_count, option_count_next;
  logic [TargetWidth-1:0] ramp_target, ramp_target_next;
  logic [DutyWidth-1:0]   duty_value, duty_value_next;
  logic                   ramp_active, ramp_active_next;
  logic                   direction_flag, direction_flag_next;
  logic [1:0]             drive_bits, drive_bits_next;

  logic                   opt_fire, tgt_fire, ramp_fire;
  logic [CountWidth-1:0]  count_mid;
  logic                   active_mid;

  assign opt_fire  = option_divider >= cfg.option_period;
  assign tgt_fire  = target_divider >= cfg.target_period;
  assign ramp_fire = ramp_divider >= cfg.ramp_period;

  assign option_divider_next = opt_fire  ? PeriodWidth'(1) : option_divider + PeriodWidth'(1);
  assign target_divider_next = tgt_fire  ? PeriodWidth'(1) : target_divider + PeriodWidth'(1);
  assign ramp_divider_next   = ramp_fire ? PeriodWidth'(1) : ramp_divider + PeriodWidth'(1);

  // option step, then adjust step, then ramp step, all within one tick
  always_comb begin
    count_mid           = option_count;
    active_mid          = ramp_active;
    direction_flag_next = direction_flag;
    drive_bits_next     = drive_bits;
    if (opt_fire) begin
      if (opt_pressed) begin
        count_mid = option_count + CountWidth'(1);
      end else if (option_count == OPT_TOGGLE_DIR) begin
        drive_bits_next     = direction_flag ? DRIVE_REVERSE : DRIVE_FORWARD;
        direction_flag_next = !direction_flag;
        active_mid          = 1'b0;
        count_mid           = '0;
      end else if (option_count == OPT_STOP) begin
        drive_bits_next = DRIVE_OFF;
        active_mid      = 1'b0;
        count_mid       = '0;
      end else if (option_count >= OPT_START_RAMP) begin
        active_mid = 1'b1;
      end
    end

    ramp_target_next = ramp_target;
    if (tgt_fire && adj_pressed) begin
      if (ramp_target > cfg.target_limit) begin
        ramp_target_next = '0;
      end else begin
        ramp_target_next = ramp_target + TargetWidth'(cfg.target_step);
      end
    end

    option_count_next = count_mid;
    ramp_active_next  = active_mid;
    duty_value_next   = duty_value;
    if (ramp_fire && active_mid) begin
      // a target above the duty range never matches, so the duty keeps wrapping
      if (TargetWidth'(duty_value) != ramp_target_next) begin
        duty_value_next = duty_value + DutyWidth'(1);
      end else begin
        ramp_active_next = 1'b0;
        ramp_target_next = '0;
      end
      option_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      option_divider <= PeriodWidth'(1);
      target_divider <= PeriodWidth'(1);
      ramp_divider   <= PeriodWidth'(1);
      option_count   <= '0;
      ramp_target    <= '0;
      duty_value     <= '0;
      ramp_active    <= 1'b0;
      direction_flag <= 1'b0;
      drive_bits     <= DRIVE_OFF;
    end else if (step) begin
      option_divider <= option_divider_next;
      target_divider <= target_divider_next;
      ramp_divider   <= ramp_divider_next;
      option_count   <= option_count_next;
      ramp_target    <= ramp_target_next;
      duty_value     <= duty_value_next;
      ramp_active    <= ramp_active_next;
      direction_flag <= direction_flag_next;
      drive_bits     <= drive_bits_next;
    end
  end

  assign result.drive_forward = drive_bits_next[0];
  assign result.drive_reverse = drive_bits_next[1];
  assign result.duty_level    = duty_value_next;
  assign result.ramping       = ramp_active_next;

`ifndef ASSERT_OFF
  a_duty_single_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && duty_value != $past(duty_value)
      |-> duty_value == $past(duty_value) + DutyWidth'(1))
    else $error("duty moved by more than one count");

  a_drive_exclusive: assert property (@(posedge clk) disable iff (rst)
    drive_bits != DRIVE_BOTH)
    else $error("both bridge drives on");
`endif

endmodule

// File: src/button_motor_soft_start_controller_unit.sv
// Button motor soft-start controller.
// Input channel: one request per 1 ms tick, carrying the two button levels
// (option_button_pressed, adjust_button_pressed), handshake in_valid/in_stall.
// Output channel: one result per tick (drive_forward, drive_reverse,
// duty_level, ramping) taken after that tick's divider and button updates,
// handshake out_valid/out_stall.
// Config: cfg_valid/cfg_ready write port, cfg_index selects the register
// (option, target and ramp periods, target step, target limit); cfg_ready is
// always high. Write only while no request is in flight.
// The buttons are registered at acceptance; the step logic then updates the
// state and loads the result register. One request per cycle is sustained
// while the receiver does not stall; the single tick step between the input
// register and the result register sets that figure.
// When the receiver stalls, the result register holds and the input
// register keeps its request; in_stall rises only once both are full.
// Reset empties both registers, clears the state, and loads the register
// defaults 1000, 10, 20, 100 and 1024.
module button_motor_soft_start_controller_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             option_button_pressed,
  input  logic                             adjust_button_pressed,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             drive_forward,
  output logic                             drive_reverse,
  output logic [bmssc_pkg::DutyWidth-1:0]  duty_level,
  output logic                             ramping,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bmssc_pkg::IndexWidth-1:0] cfg_index,
  input  logic [bmssc_pkg::DataWidth-1:0]  cfg_data
);
  import bmssc_pkg::*;

  cfg_t    cfg;
  result_t result;

  logic in_full;
  logic opt_reg, adj_reg;
  logic out_free, advance, in_take;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign advance   = in_full && out_free;
  assign in_stall  = in_full && !out_free;
  assign in_take   = in_valid && !in_stall;

  bmssc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bmssc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .opt_pressed (opt_reg),
    .adj_pressed (adj_reg),
    .cfg         (cfg),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      opt_reg <= option_button_pressed;
      adj_reg <= adjust_button_pressed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_forward <= result.drive_forward;
      drive_reverse <= result.drive_reverse;
      duty_level    <= result.duty_level;
      ramping       <= result.ramping;
    end
  end

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the result register can drain");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && in_full |=> in_full && out_valid)
    else $error("request lost while the receiver stalls");
`endif

endmodule
